### design/assert_macros.svh
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define UTAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be seen outside reset
`define UTAD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define UTAD_ASSERT(lbl, prop, msg)
`define UTAD_NEVER(lbl, cond, msg)
`endif

`endif

### design/utad_pkg.sv
package utad_pkg;

  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned HALF_W      = 32;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned NIB_W       = 4;
  localparam int unsigned MAX_DIGITS  = VALUE_W / NIB_W;
  localparam int unsigned IDX_W       = $clog2(MAX_DIGITS);
  localparam int unsigned DEC_DIGITS  = 10;
  localparam int unsigned BCD_W       = DEC_DIGITS * NIB_W;
  localparam int unsigned BITCNT_W    = $clog2(HALF_W);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [NIB_W-1:0]  DEC_RADIX    = 4'd10;
  localparam logic [NIB_W-1:0]  DABBLE_MIN   = 4'd5;
  localparam logic [NIB_W-1:0]  DABBLE_ADD   = 4'd3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_DEC    = 2'd0,
    FUNC_HEX_LO = 2'd1,
    FUNC_HEX_UP = 2'd2,
    FUNC_HEX64  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_CONV,
    FRONT_PUSH
  } front_state_e;

  typedef logic [MAX_DIGITS-1:0][NIB_W-1:0] nibbles_t;

  // one converted value waiting to be printed
  typedef struct packed {
    nibbles_t         nib;
    logic [IDX_W-1:0] top_idx;
    logic             upper;
    logic             clear;
  } job_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(logic [NIB_W-1:0] d, logic upper);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {{(CHAR_W-NIB_W){1'b0}}, d};
    if (d < DEC_RADIX) begin
      return CHAR_ZERO + d_ext;
    end else if (upper) begin
      return CHAR_UPPER_A + d_ext - {{(CHAR_W-NIB_W){1'b0}}, DEC_RADIX};
    end else begin
      return CHAR_LOWER_A + d_ext - {{(CHAR_W-NIB_W){1'b0}}, DEC_RADIX};
    end
  endfunction

endpackage

### design/utad_if.sv
// input beat channel: one value to convert
interface utad_in_if;
  logic                          valid;
  logic                          ready;
  logic [utad_pkg::VALUE_W-1:0]  value;
  logic [utad_pkg::FUNC_W-1:0]   func;
  logic                          clear_count;

  modport source (output valid, value, func, clear_count, input ready);
  modport sink   (input valid, value, func, clear_count, output ready);
endinterface

// output beat channel: one digit character
interface utad_out_if;
  logic                          valid;
  logic                          ready;
  logic [utad_pkg::CHAR_W-1:0]   digit_char;
  logic                          last;
  logic [utad_pkg::COUNT_W-1:0]  char_total;

  modport source (output valid, digit_char, last, char_total, input ready);
  modport sink   (input valid, digit_char, last, char_total, output ready);
endinterface

### design/unsigned_to_ascii_digits.sv
// Unsigned binary to ASCII digit converter.
// in_i carries one value per beat with a mode (decimal, lower-case hex,
// upper-case hex on the low 32 bits, or 64-bit lower-case hex) and a flag
// that clears the running character count before this value's digits.
// out_o carries one ASCII digit per beat, most significant first, with no
// leading zeros; zero prints as a single '0'. last marks the final digit and
// char_total gives the saturating count of characters sent so far.
// The front converts: decimal runs double dabble over the low 32 bits and
// then hands over, hex goes straight to the hand-over. The front
// accepts a new value only once the previous one is in the two-entry queue.
// The back loads each value, then prints one digit a cycle while the
// receiver takes them, so a decimal value's digits leave while the next
// value converts; 64-bit hex is bound by the back.
// A stalled receiver holds the output register, then the back, then the
// queue; the input side keeps converting until the queue fills.
// Reset empties the queue, drops any digit in flight and zeroes the count.
module unsigned_to_ascii_digits (
  input  logic   clk_i,
  input  logic   rst_ni,
  utad_in_if.sink    in_i,
  utad_out_if.source out_o
);
  import utad_pkg::*;

  `include "assert_macros.svh"

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  logic q_full, q_empty;
  logic char_ok;
  job_t push_job, pop_job;

  // conversion front
  utad_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_job_o   (push_job),
    .push_ready_i (push_ready)
  );

  // job queue between front and back
  utad_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_job_i   (push_job),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_job_o    (pop_job),
    .pop_ready_i  (pop_ready),
    .full_o       (q_full),
    .empty_o      (q_empty)
  );

  // digit printer
  utad_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_job_i   (pop_job),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

  // digit glyph falls in one of the three printable ranges
  assign char_ok =
      (out_o.digit_char >= CHAR_ZERO && out_o.digit_char <= CHAR_ZERO + 8'd9)
   || (out_o.digit_char >= CHAR_LOWER_A && out_o.digit_char <= CHAR_LOWER_A + 8'd5)
   || (out_o.digit_char >= CHAR_UPPER_A && out_o.digit_char <= CHAR_UPPER_A + 8'd5);

  // checks
  `UTAD_NEVER(a_queue_full_empty, q_full && q_empty, "queue both full and empty")
  `UTAD_ASSERT(a_front_busy, in_i.valid && in_i.ready |=> !in_i.ready, "front took two beats")
  `UTAD_ASSERT(a_total_nonzero, out_o.valid |-> out_o.char_total != '0, "zero char total")
  `UTAD_ASSERT(a_char_range, out_o.valid |-> char_ok, "bad digit char")

endmodule

### design/utad_front.sv
module utad_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  utad_in_if.sink        in_i,
  output logic           push_valid_o,
  output utad_pkg::job_t push_job_o,
  input  logic           push_ready_i
);
  import utad_pkg::*;

  front_state_e        state_q, state_d;
  logic [BITCNT_W-1:0] bitcnt_q;
  logic [VALUE_W-1:0]  word_q;
  logic [BCD_W-1:0]    bcd_q;
  logic                dec_q;
  logic                upper_q;
  logic                clear_q;
  logic [BCD_W-1:0]    bcd_adj;
  nibbles_t            nib;
  logic [IDX_W-1:0]    top_idx;
  logic                accept;

  assign accept = in_i.valid && in_i.ready;

  // add-3 correction on every bcd digit before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[i*NIB_W +: NIB_W] = (bcd_q[i*NIB_W +: NIB_W] >= DABBLE_MIN)
                                ? bcd_q[i*NIB_W +: NIB_W] + DABBLE_ADD
                                : bcd_q[i*NIB_W +: NIB_W];
    end
  end

  // digit source and position of the leading digit
  always_comb begin
    nib = dec_q ? nibbles_t'({{(VALUE_W-BCD_W){1'b0}}, bcd_q}) : nibbles_t'(word_q);
    top_idx = '0;
    for (int i = 1; i < MAX_DIGITS; i++) begin
      if (nib[i] != '0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  assign push_job_o = '{nib: nib, top_idx: top_idx, upper: upper_q, clear: clear_q};

  // next state and handshakes
  always_comb begin
    state_d      = state_q;
    in_i.ready   = 1'b0;
    push_valid_o = 1'b0;
    unique case (state_q)
      FRONT_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = (func_e'(in_i.func) == FUNC_DEC) ? FRONT_CONV : FRONT_PUSH;
        end
      end
      FRONT_CONV: begin
        if (bitcnt_q == BITCNT_W'(HALF_W - 1)) begin
          state_d = FRONT_PUSH;
        end
      end
      FRONT_PUSH: begin
        push_valid_o = 1'b1;
        if (push_ready_i) begin
          state_d = FRONT_IDLE;
        end
      end
      default: state_d = FRONT_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FRONT_IDLE;
      bitcnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        bitcnt_q <= '0;
      end else if (state_q == FRONT_CONV) begin
        bitcnt_q <= bitcnt_q + 1'b1;
      end
    end
  end

  // conversion datapath, double dabble one bit a cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q  <= (func_e'(in_i.func) == FUNC_HEX64) ? in_i.value
               : {{(VALUE_W-HALF_W){1'b0}}, in_i.value[HALF_W-1:0]};
      bcd_q   <= '0;
      dec_q   <= func_e'(in_i.func) == FUNC_DEC;
      upper_q <= func_e'(in_i.func) == FUNC_HEX_UP;
      clear_q <= in_i.clear_count;
    end else if (state_q == FRONT_CONV) begin
      bcd_q  <= {bcd_adj[BCD_W-2:0], word_q[HALF_W-1]};
      word_q <= {word_q[VALUE_W-2:0], 1'b0};
    end
  end

endmodule

### design/utad_queue.sv
module utad_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  utad_pkg::job_t push_job_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output utad_pkg::job_t pop_job_o,
  input  logic           pop_ready_i,
  output logic           full_o,
  output logic           empty_o
);
  import utad_pkg::*;

  job_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o       = count_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o      = count_q == '0;
  assign push_ready_o = !full_o;
  assign pop_valid_o  = !empty_o;
  assign pop_job_o    = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

### design/utad_back.sv
module utad_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  input  utad_pkg::job_t pop_job_i,
  output logic           pop_ready_o,
  utad_out_if.source     out_o
);
  import utad_pkg::*;

  logic               busy_q;
  logic               clear_q;
  logic [IDX_W-1:0]   idx_q;
  logic [COUNT_W-1:0] count_q;
  logic               out_valid_q;
  nibbles_t           nib_q;
  logic               upper_q;
  logic [CHAR_W-1:0]  digit_q;
  logic               last_q;
  logic [COUNT_W-1:0] total_q;
  logic [COUNT_W-1:0] base;
  logic [COUNT_W-1:0] count_next;
  logic               load;
  logic               emit;

  assign pop_ready_o = !busy_q;
  assign load        = pop_valid_i && pop_ready_o;
  assign emit        = busy_q && (!out_valid_q || out_o.ready);

  // saturating character count, cleared ahead of the first digit
  assign base       = clear_q ? '0 : count_q;
  assign count_next = (&base) ? base : base + 1'b1;

  assign out_o.valid      = out_valid_q;
  assign out_o.digit_char = digit_q;
  assign out_o.last       = last_q;
  assign out_o.char_total = total_q;

  // sequencing and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      clear_q     <= 1'b0;
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q  <= 1'b1;
        clear_q <= pop_job_i.clear;
        idx_q   <= pop_job_i.top_idx;
      end else if (emit) begin
        clear_q <= 1'b0;
        count_q <= count_next;
        if (idx_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q - 1'b1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // digit payload and output beat register
  always_ff @(posedge clk_i) begin
    if (load) begin
      nib_q   <= pop_job_i.nib;
      upper_q <= pop_job_i.upper;
    end
    if (emit) begin
      digit_q <= digit_to_ascii(nib_q[idx_q], upper_q);
      last_q  <= idx_q == '0;
      total_q <= count_next;
    end
  end

endmodule
